// ===== src/saws_pkg.sv =====
// ----------------------------------------------------------------------------
// Stop-and-wait sender package
// Shared codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package saws_pkg;

    // Input operation codes.
    localparam logic [1:0] OP_MSG  = 2'd0;
    localparam logic [1:0] OP_PKT  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Result event codes.
    localparam logic [2:0] EV_SENT        = 3'd0;
    localparam logic [2:0] EV_BUSY        = 3'd1;
    localparam logic [2:0] EV_ACKED       = 3'd2;
    localparam logic [2:0] EV_CORRUPT     = 3'd3;
    localparam logic [2:0] EV_WRONG_ACK   = 3'd4;
    localparam logic [2:0] EV_NOT_WAITING = 3'd5;

    localparam logic [15:0] TIMEOUT_RESET = 16'd15;

    typedef enum logic [1:0] {
        ST_ACCEPT,
        ST_EMIT,
        ST_JUDGE,
        ST_SINGLE
    } state_t;

    typedef struct packed {
        logic       msg_store;
        logic       msg_finish;
        logic       pkt_add;
        logic       pkt_last;
        logic       tick_step;
        logic       tick_clear;
        logic       emit_start;
        logic       emit_run;
        logic       single_load;
        logic [2:0] kind;
        logic       send_seq;
    } cmd_t;

    typedef struct packed {
        logic tick_hit;
        logic chk_ok;
        logic ack_ok;
        logic out_free;
        logic emit_done;
    } stat_t;

endpackage

`default_nettype wire

// ===== src/saws_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
`default_nettype none

module saws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 20,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/saws_datapath.sv =====
// ----------------------------------------------------------------------------
// Stop-and-wait sender datapath
// Payload store, message and packet sums, timeout counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module saws_datapath #(
    parameter int PAYLOAD_BYTES = 20
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic signed [7:0]  s_data_byte,
    input  wire logic signed [31:0] s_seq_in,
    input  wire logic signed [31:0] s_ack_in,
    input  wire logic signed [31:0] s_checksum_in,
    input  wire logic               cfg_valid,
    input  wire logic        [15:0] cfg_data,
    input  wire saws_pkg::cmd_t     cmd,
    output saws_pkg::stat_t         stat,
    input  wire logic               m_ready,
    output logic                    m_valid,
    output logic             [2:0]  m_event_kind,
    output logic                    m_seq_out,
    output logic signed     [31:0]  m_checksum_out,
    output logic signed      [7:0]  m_byte_out,
    output logic                    m_last_out
);

    import saws_pkg::*;

    localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int PW = $clog2(PAYLOAD_BYTES + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(PAYLOAD_BYTES - 1);
    localparam logic [PW-1:0] NUM_BYTES = PW'(PAYLOAD_BYTES);

    logic [31:0]   byte_ext;
    logic          pos_room;
    logic [31:0]   msg_sum_add;
    logic [31:0]   pkt_total;
    logic [15:0]   tick_inc;

    logic [15:0]   timeout_reg;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] len_reg;
    logic [31:0]   msg_sum_reg;
    logic [31:0]   saved_chk_reg;
    logic [31:0]   pkt_sum_reg;
    logic [15:0]   tick_reg;
    logic [31:0]   j_total_reg;
    logic [31:0]   j_hdr_reg;
    logic [31:0]   j_chk_reg;
    logic          j_ack_ok_reg;

    logic [PW-1:0] rd_idx_reg;
    logic [PW-1:0] out_idx_reg;
    logic          dv_reg;
    logic          out_free;
    logic          emit_load;
    logic          ram_re;
    logic          ram_we;
    logic [7:0]    ram_rdata;

    logic          m_valid_reg;
    logic [2:0]    kind_reg;
    logic          seq_reg;
    logic [31:0]   chk_reg;
    logic [7:0]    byte_reg;
    logic          last_reg;

    assign byte_ext    = {{24{s_data_byte[7]}}, s_data_byte};
    assign pos_room    = pos_reg < NUM_BYTES;
    assign msg_sum_add = msg_sum_reg + (pos_room ? byte_ext : 32'd0);
    assign pkt_total   = pkt_sum_reg + byte_ext;
    assign tick_inc    = (&tick_reg) ? tick_reg : tick_reg + 16'd1;

    assign ram_we    = cmd.msg_store && pos_room;
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_load = cmd.emit_run && dv_reg && out_free;
    assign ram_re    = cmd.emit_run && (rd_idx_reg < NUM_BYTES) && (!dv_reg || emit_load);

    assign stat.tick_hit  = tick_inc >= timeout_reg;
    assign stat.chk_ok    = j_chk_reg == (j_hdr_reg + j_total_reg);
    assign stat.ack_ok    = j_ack_ok_reg;
    assign stat.out_free  = out_free;
    assign stat.emit_done = emit_load && (out_idx_reg == LAST_IDX);

    saws_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (pos_reg[AW-1:0]),
        .wdata (s_data_byte),
        .re    (ram_re),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Control state and counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            pos_reg     <= '0;
            msg_sum_reg <= '0;
            pkt_sum_reg <= '0;
            tick_reg    <= '0;
            rd_idx_reg  <= '0;
            out_idx_reg <= '0;
            dv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                timeout_reg <= cfg_data;
            end

            if (cmd.msg_finish) begin
                pos_reg     <= '0;
                msg_sum_reg <= '0;
            end else if (ram_we) begin
                pos_reg     <= pos_reg + PW'(1);
                msg_sum_reg <= msg_sum_add;
            end

            if (cmd.pkt_add) begin
                pkt_sum_reg <= cmd.pkt_last ? 32'd0 : pkt_total;
            end

            if (cmd.tick_clear) begin
                tick_reg <= '0;
            end else if (cmd.tick_step) begin
                tick_reg <= stat.tick_hit ? 16'd0 : tick_inc;
            end

            if (cmd.emit_start) begin
                rd_idx_reg  <= '0;
                out_idx_reg <= '0;
                dv_reg      <= 1'b0;
            end else if (cmd.emit_run) begin
                if (ram_re) begin
                    rd_idx_reg <= rd_idx_reg + PW'(1);
                end
                if (emit_load) begin
                    out_idx_reg <= out_idx_reg + PW'(1);
                end
                dv_reg <= ram_re ? 1'b1 : (emit_load ? 1'b0 : dv_reg);
            end

            if (emit_load || cmd.single_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.msg_finish) begin
            saved_chk_reg <= msg_sum_add + {31'd0, cmd.send_seq};
            len_reg       <= pos_room ? pos_reg + PW'(1) : pos_reg;
        end

        if (cmd.pkt_add && cmd.pkt_last) begin
            j_total_reg  <= pkt_total;
            j_hdr_reg    <= s_seq_in + s_ack_in;
            j_chk_reg    <= s_checksum_in;
            j_ack_ok_reg <= s_ack_in == {31'd0, cmd.send_seq};
        end

        if (emit_load) begin
            kind_reg <= EV_SENT;
            seq_reg  <= cmd.send_seq;
            chk_reg  <= saved_chk_reg;
            // Positions past the end of a short message go out as zero.
            byte_reg <= (out_idx_reg < len_reg) ? ram_rdata : 8'd0;
            last_reg <= out_idx_reg == LAST_IDX;
        end else if (cmd.single_load) begin
            kind_reg <= cmd.kind;
            seq_reg  <= 1'b0;
            chk_reg  <= '0;
            byte_reg <= '0;
            last_reg <= 1'b1;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_kind   = kind_reg;
    assign m_seq_out      = seq_reg;
    assign m_checksum_out = chk_reg;
    assign m_byte_out     = byte_reg;
    assign m_last_out     = last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.single_load |-> !cmd.emit_run)
        else $error("single result loaded during a packet send");

endmodule

`default_nettype wire

// ===== src/saws_ctrl.sv =====
// ----------------------------------------------------------------------------
// Stop-and-wait sender controller
// Decodes accepted items, tracks the alternating bit and sequences results.
// ----------------------------------------------------------------------------
`default_nettype none

module saws_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic        [1:0] s_operation,
    input  wire logic              s_last_byte,
    input  wire saws_pkg::stat_t   stat,
    output saws_pkg::cmd_t         cmd
);

    import saws_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic       waiting_reg;
    logic       waiting_next;
    logic       send_seq_reg;
    logic       send_seq_next;
    logic [2:0] kind_reg;
    logic [2:0] kind_next;
    logic       accept;

    assign s_ready = state_reg == ST_ACCEPT;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_ACCEPT;
            waiting_reg  <= 1'b0;
            send_seq_reg <= 1'b0;
            kind_reg     <= EV_SENT;
        end else begin
            state_reg    <= state_next;
            waiting_reg  <= waiting_next;
            send_seq_reg <= send_seq_next;
            kind_reg     <= kind_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCEPT: begin
                if (accept) begin
                    case (s_operation)
                        OP_MSG: begin
                            if (s_last_byte) begin
                                state_next = waiting_reg ? ST_SINGLE : ST_EMIT;
                            end
                        end
                        OP_PKT: begin
                            if (s_last_byte) begin
                                state_next = waiting_reg ? ST_JUDGE : ST_SINGLE;
                            end
                        end
                        OP_TICK: begin
                            if (waiting_reg && stat.tick_hit) begin
                                state_next = ST_EMIT;
                            end
                        end
                        default: state_next = ST_ACCEPT;
                    endcase
                end
            end
            ST_EMIT: begin
                if (stat.emit_done) begin
                    state_next = ST_ACCEPT;
                end
            end
            ST_JUDGE:  state_next = ST_SINGLE;
            ST_SINGLE: begin
                if (stat.out_free) begin
                    state_next = ST_ACCEPT;
                end
            end
            default: state_next = ST_ACCEPT;
        endcase
    end

    // Outputs and protocol state.
    always_comb begin
        cmd           = '0;
        cmd.send_seq  = send_seq_reg;
        cmd.kind      = kind_reg;
        waiting_next  = waiting_reg;
        send_seq_next = send_seq_reg;
        kind_next     = kind_reg;
        case (state_reg)
            ST_ACCEPT: begin
                if (accept) begin
                    case (s_operation)
                        OP_MSG: begin
                            if (waiting_reg) begin
                                kind_next = EV_BUSY;
                            end else begin
                                cmd.msg_store = 1'b1;
                                if (s_last_byte) begin
                                    cmd.msg_finish = 1'b1;
                                    cmd.tick_clear = 1'b1;
                                    cmd.emit_start = 1'b1;
                                    waiting_next   = 1'b1;
                                end
                            end
                        end
                        OP_PKT: begin
                            cmd.pkt_add  = 1'b1;
                            cmd.pkt_last = s_last_byte;
                            kind_next    = EV_NOT_WAITING;
                        end
                        OP_TICK: begin
                            if (waiting_reg) begin
                                cmd.tick_step  = 1'b1;
                                cmd.emit_start = stat.tick_hit;
                            end
                        end
                        default: cmd.pkt_add = 1'b0;
                    endcase
                end
            end
            ST_EMIT: cmd.emit_run = 1'b1;
            ST_JUDGE: begin
                if (!stat.chk_ok) begin
                    kind_next = EV_CORRUPT;
                end else if (!stat.ack_ok) begin
                    kind_next = EV_WRONG_ACK;
                end else begin
                    kind_next      = EV_ACKED;
                    send_seq_next  = !send_seq_reg;
                    waiting_next   = 1'b0;
                    cmd.tick_clear = 1'b1;
                end
            end
            ST_SINGLE: cmd.single_load = stat.out_free;
            default: cmd.emit_run = 1'b0;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> waiting_reg)
        else $error("packet send while not waiting for an acknowledgement");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_JUDGE |=> state_reg == ST_SINGLE)
        else $error("judgement not followed by its result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        send_seq_reg != $past(send_seq_reg) |-> $past(state_reg) == ST_JUDGE)
        else $error("sequence bit flipped outside an acknowledgement");

endmodule

`default_nettype wire

// ===== src/stop_and_wait_sender_core.sv =====
// ----------------------------------------------------------------------------
// Stop-and-wait sender core
// Alternating-bit sender with stored packet, checksum and timeout resend.
// ----------------------------------------------------------------------------
// An item that gives no result leaves the input ready, and the next may follow
// in the following cycle. A message's last byte while not waiting, or a tick
// that reaches the timeout while waiting, starts a packet send of PAYLOAD_BYTES
// transfers, one byte per cycle while the result side is ready, read through
// the registered read port of the payload RAM. A packet's last byte while
// waiting goes through accept, checksum compare and result load. A message's
// last byte while waiting or a packet's last byte while not waiting goes
// through accept and result load. No input is taken while results of the
// current item are still being produced.
`default_nettype none

module stop_and_wait_sender_core #(
    parameter int PAYLOAD_BYTES = 20
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic        [15:0] cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic         [1:0] s_operation,
    input  wire logic signed  [7:0] s_data_byte,
    input  wire logic               s_last_byte,
    input  wire logic signed [31:0] s_seq_in,
    input  wire logic signed [31:0] s_ack_in,
    input  wire logic signed [31:0] s_checksum_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic              [2:0] m_event_kind,
    output logic                    m_seq_out,
    output logic                    m_ack_out,
    output logic signed      [31:0] m_checksum_out,
    output logic signed       [7:0] m_byte_out,
    output logic                    m_last_out
);

    import saws_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;
    assign m_ack_out = 1'b0;

    saws_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_last_byte (s_last_byte),
        .stat        (stat),
        .cmd         (cmd)
    );

    saws_datapath #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_data_byte    (s_data_byte),
        .s_seq_in       (s_seq_in),
        .s_ack_in       (s_ack_in),
        .s_checksum_in  (s_checksum_in),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .stat           (stat),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_event_kind   (m_event_kind),
        .m_seq_out      (m_seq_out),
        .m_checksum_out (m_checksum_out),
        .m_byte_out     (m_byte_out),
        .m_last_out     (m_last_out)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Stop-and-wait sender testbench
// Drives message bytes, link packet bytes and timer ticks into the sender
// and checks every result transfer against a cycle-free behavioral predictor.
// A short directed table comes first, then random traffic in phases with
// different timeouts and different amounts of idling on both channels.
// ----------------------------------------------------------------------------

module tb_top;

    import saws_pkg::*;

    localparam int         PAYLOAD_BYTES   = 20;
    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam int         SETTLE_CYCLES   = 10;
    localparam int         PHASE_ITEMS     = 50;
    localparam int         PHASES          = 6;
    localparam logic       CHECK_PREDICTED = 1'b0;
    localparam logic       CHECK_TYPED     = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data;
        logic        last;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [31:0] chk;
    } link_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        seq;
        logic        ack;
        logic [31:0] chk;
        logic [7:0]  data;
        logic        last;
    } sender_event_t;

    typedef struct packed {
        link_item_t item;
        logic       how;
        logic [2:0] kind;
    } directed_row_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic        [15:0] cfg_data      = '0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic         [1:0] s_operation   = '0;
    logic signed  [7:0] s_data_byte   = '0;
    logic               s_last_byte   = 1'b0;
    logic signed [31:0] s_seq_in      = '0;
    logic signed [31:0] s_ack_in      = '0;
    logic signed [31:0] s_checksum_in = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic         [2:0] m_event_kind;
    logic               m_seq_out;
    logic               m_ack_out;
    logic signed [31:0] m_checksum_out;
    logic signed  [7:0] m_byte_out;
    logic               m_last_out;

    // Predictor state.
    logic        [15:0] timeout_setting = 16'd15;
    logic               awaiting_ack    = 1'b0;
    logic               cur_seq         = 1'b0;
    logic         [7:0] held_payload[PAYLOAD_BYTES];
    logic        [31:0] held_checksum   = '0;
    logic        [31:0] msg_total       = '0;
    int                 msg_fill        = 0;
    logic        [31:0] link_total      = '0;
    logic        [15:0] ticks_seen      = '0;

    sender_event_t      expected_events[$];
    sender_event_t      step_events[$];
    int                 mismatches      = 0;
    int                 useful_items    = 0;
    int                 tx_idle_pct     = 36;
    int                 rx_idle_pct     = 73;

    stop_and_wait_sender_core #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .s_seq_in      (s_seq_in),
        .s_ack_in      (s_ack_in),
        .s_checksum_in (s_checksum_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_seq_out     (m_seq_out),
        .m_ack_out     (m_ack_out),
        .m_checksum_out(m_checksum_out),
        .m_byte_out    (m_byte_out),
        .m_last_out    (m_last_out)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [31:0] widen(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        sender_event_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_events.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual kind %0d",
                         $time, m_event_kind);
                mismatches++;
            end else begin
                want = expected_events.pop_front();
                check_field("event_kind", 32'(want.kind), 32'(m_event_kind));
                check_field("seq_out", 32'(want.seq), 32'(m_seq_out));
                check_field("ack_out", 32'(want.ack), 32'(m_ack_out));
                check_field("checksum_out", want.chk, m_checksum_out);
                check_field("byte_out", 32'(want.data), 32'($unsigned(m_byte_out)));
                check_field("last_out", 32'(want.last), 32'(m_last_out));
            end
        end
    end

    task automatic push_notice(input logic [2:0] kind);
        sender_event_t e;
        e      = '0;
        e.kind = kind;
        e.last = 1'b1;
        step_events.push_back(e);
    endtask

    task automatic push_packet();
        sender_event_t e;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            e.kind = EV_SENT;
            e.seq  = cur_seq;
            e.ack  = 1'b0;
            e.chk  = held_checksum;
            e.data = held_payload[i];
            e.last = (i == PAYLOAD_BYTES - 1);
            step_events.push_back(e);
        end
    endtask

    // Advances the predictor by one accepted item and leaves its results
    // in step_events.
    task automatic sender_step(input link_item_t it);
        logic [31:0] total;
        step_events.delete();
        case (it.op)
            OP_MSG: begin
                if (awaiting_ack) begin
                    if (it.last) push_notice(EV_BUSY);
                end else begin
                    // Bytes past the payload size are dropped without summing.
                    if (msg_fill < PAYLOAD_BYTES) begin
                        held_payload[msg_fill] = it.data;
                        msg_total += widen(it.data);
                        msg_fill++;
                    end
                    if (it.last) begin
                        while (msg_fill < PAYLOAD_BYTES) begin
                            held_payload[msg_fill] = 8'h00;
                            msg_fill++;
                        end
                        held_checksum = {31'b0, cur_seq} + msg_total;
                        msg_total     = '0;
                        msg_fill      = 0;
                        awaiting_ack  = 1'b1;
                        ticks_seen    = '0;
                        push_packet();
                    end
                end
            end
            OP_PKT: begin
                link_total += widen(it.data);
                if (it.last) begin
                    total      = link_total;
                    link_total = '0;
                    if (!awaiting_ack) begin
                        push_notice(EV_NOT_WAITING);
                    end else if (it.chk != it.seq + it.ack + total) begin
                        push_notice(EV_CORRUPT);
                    end else if (it.ack != {31'b0, cur_seq}) begin
                        push_notice(EV_WRONG_ACK);
                    end else begin
                        cur_seq      = ~cur_seq;
                        awaiting_ack = 1'b0;
                        ticks_seen   = '0;
                        push_notice(EV_ACKED);
                    end
                end
            end
            OP_TICK: begin
                if (awaiting_ack) begin
                    if (ticks_seen != 16'hFFFF) ticks_seen++;
                    if (ticks_seen >= timeout_setting) begin
                        ticks_seen = '0;
                        push_packet();
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic drive_item(input link_item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= it.op;
        s_data_byte   <= it.data;
        s_last_byte   <= it.last;
        s_seq_in      <= it.seq;
        s_ack_in      <= it.ack;
        s_checksum_in <= it.chk;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic issue(input link_item_t it);
        drive_item(it);
        if (!(it.op == OP_UNUSED || (it.op == OP_TICK && !awaiting_ack))) useful_items++;
        sender_step(it);
        expected_events = {expected_events, step_events};
    endtask

    // Stops the sender side until every expected result has come, then lets
    // the block finish any item that causes no result.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid       <= 1'b0;
        timeout_setting = value;
    endtask

    task automatic send_message(input int len);
        link_item_t it;
        for (int b = 0; b < len; b++) begin
            it      = '0;
            it.op   = OP_MSG;
            it.data = 8'($urandom);
            it.last = (b == len - 1);
            it.seq  = $urandom;
            it.ack  = $urandom;
            it.chk  = $urandom;
            issue(it);
        end
    endtask

    // A packet whose header, when shaped, is built to be accepted most of the time; the
    // checksum is taken from the running sum at the moment the last byte goes.
    task automatic send_packet(input int len, input logic shaped);
        link_item_t it;
        for (int b = 0; b < len; b++) begin
            it      = '0;
            it.op   = OP_PKT;
            it.data = 8'($urandom);
            it.last = (b == len - 1);
            it.seq  = $urandom;
            it.ack  = $urandom;
            it.chk  = $urandom;
            if (shaped && it.last) begin
                if ($urandom_range(9) < 7) it.ack = {31'b0, cur_seq};
                it.chk = it.seq + it.ack + link_total + widen(it.data);
                if ($urandom_range(9) == 0) it.chk ^= 32'h1 << $urandom_range(31);
            end
            issue(it);
        end
    endtask

    task automatic tick_burst(input int n);
        link_item_t it;
        for (int b = 0; b < n; b++) begin
            it      = '0;
            it.op   = OP_TICK;
            it.data = 8'($urandom);
            it.last = 1'($urandom);
            issue(it);
        end
    endtask

    task automatic noise_item();
        link_item_t it;
        it.op   = 2'($urandom_range(3));
        it.data = 8'($urandom);
        it.last = 1'($urandom);
        it.seq  = $urandom;
        it.ack  = $urandom;
        it.chk  = $urandom;
        issue(it);
    endtask

    function automatic directed_row_t row(input logic [1:0] op, input logic [7:0] data,
                                          input logic last, input logic [31:0] seq,
                                          input logic [31:0] ack, input logic [31:0] chk,
                                          input logic how, input logic [2:0] kind);
        directed_row_t r;
        r.item = '{op: op, data: data, last: last, seq: seq, ack: ack, chk: chk};
        r.how  = how;
        r.kind = kind;
        return r;
    endfunction

    initial begin : stimulus
        directed_row_t directed_rows[20];
        logic   [15:0] phase_timeout[PHASES];
        int            phase_goal;
        int            cap;
        int            pick;

        for (int i = 0; i < PAYLOAD_BYTES; i++) held_payload[i] = 8'h00;

        // Timeout is 2 during this table, so the second tick resends.
        directed_rows[0]  = row(OP_TICK,   8'h00, 1'b0, 32'h0, 32'h0, 32'h0,
                                CHECK_PREDICTED, EV_SENT);
        directed_rows[1]  = row(OP_UNUSED, 8'h55, 1'b1, 32'h0, 32'h0, 32'h0,
                                CHECK_PREDICTED, EV_SENT);
        directed_rows[2]  = row(OP_PKT,    8'h00, 1'b1, 32'h0, 32'h0, 32'h0,
                                CHECK_TYPED, EV_NOT_WAITING);
        directed_rows[3]  = row(OP_MSG,    8'h7F, 1'b0, 32'h0, 32'h0, 32'h0,
                                CHECK_PREDICTED, EV_SENT);
        directed_rows[4]  = row(OP_MSG,    8'h80, 1'b0, 32'h0, 32'h0, 32'h0,
                                CHECK_PREDICTED, EV_SENT);
        directed_rows[5]  = row(OP_MSG,    8'hFF, 1'b1, 32'h0, 32'h0, 32'h0,
                                CHECK_PREDICTED, EV_SENT);
        directed_rows[6]  = row(OP_MSG,    8'h05, 1'b0, 32'h0, 32'h0, 32'h0,
                                CHECK_PREDICTED, EV_SENT);
        directed_rows[7]  = row(OP_MSG,    8'h06, 1'b1, 32'h0, 32'h0, 32'h0,
                                CHECK_TYPED, EV_BUSY);
        directed_rows[8]  = row(OP_TICK,   8'h00, 1'b0, 32'h0, 32'h0, 32'h0,
                                CHECK_PREDICTED, EV_SENT);
        directed_rows[9]  = row(OP_TICK,   8'h00, 1'b0, 32'h0, 32'h0, 32'h0,
                                CHECK_PREDICTED, EV_SENT);
        directed_rows[10] = row(OP_PKT,    8'h00, 1'b1, 32'h0, 32'h0, 32'h1,
                                CHECK_TYPED, EV_CORRUPT);
        directed_rows[11] = row(OP_PKT,    8'h00, 1'b1, 32'h0, 32'h1, 32'h1,
                                CHECK_TYPED, EV_WRONG_ACK);
        directed_rows[12] = row(OP_PKT,    8'h7F, 1'b0, 32'h0, 32'h0, 32'h0,
                                CHECK_PREDICTED, EV_SENT);
        directed_rows[13] = row(OP_PKT,    8'h80, 1'b1, 32'h7FFFFFFF, 32'h0, 32'h7FFFFFFE,
                                CHECK_TYPED, EV_ACKED);
        directed_rows[14] = row(OP_MSG,    8'h80, 1'b1, 32'h0, 32'h0, 32'h0,
                                CHECK_PREDICTED, EV_SENT);
        directed_rows[15] = row(OP_TICK,   8'h00, 1'b1, 32'h0, 32'h0, 32'h0,
                                CHECK_PREDICTED, EV_SENT);
        directed_rows[16] = row(OP_TICK,   8'h00, 1'b1, 32'h0, 32'h0, 32'h0,
                                CHECK_PREDICTED, EV_SENT);
        directed_rows[17] = row(OP_PKT,    8'hFF, 1'b1, 32'h80000000, 32'h1, 32'h80000000,
                                CHECK_TYPED, EV_ACKED);
        directed_rows[18] = row(OP_PKT,    8'h00, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                32'hFFFFFFFE, CHECK_TYPED, EV_NOT_WAITING);
        directed_rows[19] = row(OP_TICK,   8'h00, 1'b1, 32'h0, 32'h0, 32'h0,
                                CHECK_PREDICTED, EV_SENT);

        phase_timeout[0] = 16'd0;
        phase_timeout[1] = 16'hFFFF;
        phase_timeout[2] = 16'd1;
        phase_timeout[3] = 16'($urandom_range(2, 20));
        phase_timeout[4] = TIMEOUT_RESET;
        phase_timeout[5] = 16'd3;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_timeout(16'd2);

        foreach (directed_rows[i]) begin
            drive_item(directed_rows[i].item);
            sender_step(directed_rows[i].item);
            if (directed_rows[i].how == CHECK_TYPED) begin
                step_events.delete();
                push_notice(directed_rows[i].kind);
            end
            expected_events = {expected_events, step_events};
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            tx_idle_pct = (p < 2) ? 36 : (p < 4) ? 73 : 0;
            rx_idle_pct = (p < 2) ? 73 : (p < 4) ? 36 : 0;
            write_timeout(phase_timeout[p]);
            phase_goal = useful_items + PHASE_ITEMS;
            while (useful_items < phase_goal) begin
                if ($urandom_range(49) == 0) wait_idle();
                pick = $urandom_range(99);
                if (!awaiting_ack) begin
                    if (pick < 70) begin
                        // Now and then a message longer than the payload.
                        if ($urandom_range(9) == 0) send_message($urandom_range(21, 24));
                        else send_message($urandom_range(1, PAYLOAD_BYTES));
                    end else if (pick < 80) begin
                        send_packet($urandom_range(1, 3), 1'b0);
                    end else if (pick < 90) begin
                        tick_burst($urandom_range(1, 3));
                    end else begin
                        noise_item();
                    end
                end else begin
                    if (pick < 45) begin
                        send_packet($urandom_range(1, 4), 1'b1);
                    end else if (pick < 70) begin
                        cap = (timeout_setting >= 16'd19) ? 20 : int'(timeout_setting) + 1;
                        tick_burst($urandom_range(1, cap));
                    end else if (pick < 85) begin
                        send_message($urandom_range(1, 4));
                    end else begin
                        noise_item();
                    end
                end
            end
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
